// File: rtl/calu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calu_pkg
// Shared operation codes, adjust constants and stage records for the ALU.
// ----------------------------------------------------------------------------
package calu_pkg;

  // operation codes
  typedef enum logic [4:0] {
    CMD_ADC = 5'd0,
    CMD_AND = 5'd1,
    CMD_ASL = 5'd2,
    CMD_BIT = 5'd3,
    CMD_CMP = 5'd4,
    CMD_CPX = 5'd5,
    CMD_CPY = 5'd6,
    CMD_DEC = 5'd7,
    CMD_EOR = 5'd8,
    CMD_INC = 5'd9,
    CMD_LD  = 5'd10,
    CMD_LSR = 5'd11,
    CMD_ORA = 5'd12,
    CMD_ROL = 5'd13,
    CMD_ROR = 5'd14,
    CMD_SBC = 5'd15,
    CMD_TRB = 5'd16,
    CMD_TSB = 5'd17
  } cmd_t;

  // bcd adjust constants
  localparam logic [4:0] LOW_LIMIT  = 5'h09;
  localparam logic [3:0] LOW_ADJ    = 4'h6;
  localparam logic [8:0] HIGH_LIMIT = 9'h09f;
  localparam logic [8:0] HIGH_ADJ   = 9'h060;

  // after stage one: low nibble done, non-arithmetic result done
  typedef struct packed {
    logic       valid;
    logic       arith;
    logic       sub;
    logic       dec;
    logic [7:0] a;
    logic [7:0] b;
    logic       c_in;
    logic       v_in;
    logic       lc;
    logic [3:0] low;
    logic [7:0] r;
    logic       c;
    logic       v;
    logic       z;
    logic       n;
  } calu_s1_t;

  // after stage two: high bcd sum and binary sum
  typedef struct packed {
    logic       valid;
    logic       arith;
    logic       sub;
    logic       dec;
    logic       v_in;
    logic [8:0] hsum;
    logic [8:0] bsum;
    logic       bin_v;
    logic [7:0] r;
    logic       c;
    logic       v;
    logic       z;
    logic       n;
  } calu_s2_t;

endpackage

// File: rtl/cpu_alu_with_bcd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_alu_with_bcd_core
// 8-bit processor ALU with binary and bcd add and subtract.
// ----------------------------------------------------------------------------
// One item enters per clock and busy stays low. Every item gives its result
// on the result ports for one cycle with done high; the receiver must take
// it then. The item passes through three register stages: low nibble add
// and adjust, high part sum, high part adjust and flags. Results hold
// between strobes. Flags an operation does not write pass through from the
// item.
module cpu_alu_with_bcd_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [4:0] command,
  input  logic [7:0] operand,
  input  logic [7:0] accumulator,
  input  logic [7:0] index_x,
  input  logic [7:0] index_y,
  input  logic       carry_in,
  input  logic       overflow_in,
  input  logic       decimal_mode,
  output logic       done,
  output logic [7:0] result,
  output logic       carry_out,
  output logic       overflow_out,
  output logic       zero_out,
  output logic       negative_out,
  output logic       extra_cycle
);

  calu_pkg::calu_s1_t s1;
  calu_pkg::calu_s2_t s2;
  logic               accept;

  // pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  calu_prep u_prep (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (accept),
    .command      (command),
    .operand      (operand),
    .accumulator  (accumulator),
    .index_x      (index_x),
    .index_y      (index_y),
    .carry_in     (carry_in),
    .overflow_in  (overflow_in),
    .decimal_mode (decimal_mode),
    .s1           (s1)
  );

  calu_sum u_sum (
    .clk (clk),
    .rst (rst),
    .s1  (s1),
    .s2  (s2)
  );

  calu_finish u_finish (
    .clk          (clk),
    .rst          (rst),
    .s2           (s2),
    .done         (done),
    .result       (result),
    .carry_out    (carry_out),
    .overflow_out (overflow_out),
    .zero_out     (zero_out),
    .negative_out (negative_out),
    .extra_cycle  (extra_cycle)
  );

  // every accepted item reaches the output with done high
  a_item_out: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 done)
    else $error("accepted item did not reach the output");

  // no result strobe without an accepted item
  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 3))
    else $error("result strobe without an accepted item");

  // extra cycle only for items that came in decimal mode
  a_extra_dec: assert property (@(posedge clk) disable iff (rst)
    (done && extra_cycle) |-> $past(decimal_mode, 3))
    else $error("extra cycle mark on a binary item");

  // decimal arithmetic keeps the overflow flag
  a_dec_ovf: assert property (@(posedge clk) disable iff (rst)
    (done && extra_cycle) |-> (overflow_out == $past(overflow_in, 3)))
    else $error("decimal arithmetic changed overflow");

endmodule

// File: rtl/calu_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calu_prep
// Stage one: decode, operand complement, low nibble add and bcd adjust, and
// the complete result of every non-arithmetic operation.
// ----------------------------------------------------------------------------
module calu_prep (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [4:0]          command,
  input  logic [7:0]          operand,
  input  logic [7:0]          accumulator,
  input  logic [7:0]          index_x,
  input  logic [7:0]          index_y,
  input  logic                carry_in,
  input  logic                overflow_in,
  input  logic                decimal_mode,
  output calu_pkg::calu_s1_t  s1
);

  calu_pkg::calu_s1_t s1_next;
  logic [7:0] b;
  logic [4:0] t0;
  logic [7:0] cmp_reg;
  logic [8:0] diff;
  logic       zn;
  logic       is_adc;
  logic       is_sbc;

  // arithmetic decode and low nibble
  always_comb begin
    is_adc = (command == calu_pkg::CMD_ADC);
    is_sbc = (command == calu_pkg::CMD_SBC);
    b      = is_sbc ? ~operand : operand;
    t0     = {1'b0, accumulator[3:0]} + {1'b0, b[3:0]} + {4'b0, carry_in};
  end

  // compare register select and difference
  always_comb begin
    unique case (command)
      calu_pkg::CMD_CPX: cmp_reg = index_x;
      calu_pkg::CMD_CPY: cmp_reg = index_y;
      default:           cmp_reg = accumulator;
    endcase
    diff = {1'b0, cmp_reg} - {1'b0, operand};
  end

  // stage one record
  always_comb begin
    s1_next       = '0;
    s1_next.valid = in_valid;
    s1_next.arith = is_adc | is_sbc;
    s1_next.sub   = is_sbc;
    s1_next.dec   = decimal_mode;
    s1_next.a     = accumulator;
    s1_next.b     = b;
    s1_next.c_in  = carry_in;
    s1_next.v_in  = overflow_in;
    // low nibble bcd adjust
    if (is_sbc) begin
      s1_next.lc  = t0[4];
      s1_next.low = t0[4] ? t0[3:0] : t0[3:0] - calu_pkg::LOW_ADJ;
    end else begin
      s1_next.lc  = (t0 > calu_pkg::LOW_LIMIT);
      s1_next.low = (t0 > calu_pkg::LOW_LIMIT) ? t0[3:0] + calu_pkg::LOW_ADJ : t0[3:0];
    end
    // non-arithmetic operations
    s1_next.r = accumulator;
    s1_next.c = carry_in;
    s1_next.v = overflow_in;
    s1_next.z = 1'b0;
    s1_next.n = 1'b0;
    zn        = 1'b1;
    unique case (command)
      calu_pkg::CMD_AND: s1_next.r = accumulator & operand;
      calu_pkg::CMD_ASL: begin
        s1_next.c = operand[7];
        s1_next.r = {operand[6:0], 1'b0};
      end
      calu_pkg::CMD_BIT, calu_pkg::CMD_TRB, calu_pkg::CMD_TSB: begin
        s1_next.z = ((accumulator & operand) == 8'h00);
        s1_next.v = operand[6];
        s1_next.n = operand[7];
        zn        = 1'b0;
        if (command == calu_pkg::CMD_TRB) begin
          s1_next.r = ~accumulator & operand;
        end else if (command == calu_pkg::CMD_TSB) begin
          s1_next.r = accumulator | operand;
        end
      end
      calu_pkg::CMD_CMP, calu_pkg::CMD_CPX, calu_pkg::CMD_CPY: begin
        s1_next.c = ~diff[8];
        s1_next.z = (diff[7:0] == 8'h00);
        s1_next.n = diff[7];
        s1_next.r = cmp_reg;
        zn        = 1'b0;
      end
      calu_pkg::CMD_DEC: s1_next.r = operand - 8'd1;
      calu_pkg::CMD_EOR: s1_next.r = accumulator ^ operand;
      calu_pkg::CMD_INC: s1_next.r = operand + 8'd1;
      calu_pkg::CMD_LD:  s1_next.r = operand;
      calu_pkg::CMD_LSR: begin
        s1_next.c = operand[0];
        s1_next.r = {1'b0, operand[7:1]};
      end
      calu_pkg::CMD_ORA: s1_next.r = accumulator | operand;
      calu_pkg::CMD_ROL: begin
        s1_next.r = {operand[6:0], carry_in};
        s1_next.c = operand[7];
      end
      calu_pkg::CMD_ROR: begin
        s1_next.r = {carry_in, operand[7:1]};
        s1_next.c = operand[0];
      end
      calu_pkg::CMD_ADC, calu_pkg::CMD_SBC: zn = 1'b1;
      default: zn = 1'b0;
    endcase
    if (zn) begin
      s1_next.z = (s1_next.r == 8'h00);
      s1_next.n = s1_next.r[7];
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= s1_next.valid;
    end
    s1.arith <= s1_next.arith;
    s1.sub   <= s1_next.sub;
    s1.dec   <= s1_next.dec;
    s1.a     <= s1_next.a;
    s1.b     <= s1_next.b;
    s1.c_in  <= s1_next.c_in;
    s1.v_in  <= s1_next.v_in;
    s1.lc    <= s1_next.lc;
    s1.low   <= s1_next.low;
    s1.r     <= s1_next.r;
    s1.c     <= s1_next.c;
    s1.v     <= s1_next.v;
    s1.z     <= s1_next.z;
    s1.n     <= s1_next.n;
  end

endmodule

// File: rtl/calu_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calu_sum
// Stage two: high part of the bcd sum and the full binary sum with overflow.
// ----------------------------------------------------------------------------
module calu_sum (
  input  logic                clk,
  input  logic                rst,
  input  calu_pkg::calu_s1_t  s1,
  output calu_pkg::calu_s2_t  s2
);

  logic [8:0] hsum;
  logic [8:0] bsum;
  logic       bin_v;

  // high bcd sum and binary sum
  always_comb begin
    hsum  = {1'b0, s1.a[7:4], 4'b0} + {1'b0, s1.b[7:4], 4'b0}
          + {4'b0, s1.lc, 4'b0} + {5'b0, s1.low};
    bsum  = {1'b0, s1.a} + {1'b0, s1.b} + {8'b0, s1.c_in};
    bin_v = ~(s1.a[7] ^ s1.b[7]) & (s1.a[7] ^ bsum[7]);
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2.valid <= s1.valid;
    end
    s2.arith <= s1.arith;
    s2.sub   <= s1.sub;
    s2.dec   <= s1.dec;
    s2.v_in  <= s1.v_in;
    s2.hsum  <= hsum;
    s2.bsum  <= bsum;
    s2.bin_v <= bin_v;
    s2.r     <= s1.r;
    s2.c     <= s1.c;
    s2.v     <= s1.v;
    s2.z     <= s1.z;
    s2.n     <= s1.n;
  end

endmodule

// File: rtl/calu_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calu_finish
// Stage three: high bcd adjust, result select, zero and negative flags, and
// the output register.
// ----------------------------------------------------------------------------
module calu_finish (
  input  logic                clk,
  input  logic                rst,
  input  calu_pkg::calu_s2_t  s2,
  output logic                done,
  output logic [7:0]          result,
  output logic                carry_out,
  output logic                overflow_out,
  output logic                zero_out,
  output logic                negative_out,
  output logic                extra_cycle
);

  logic [8:0] dsum;
  logic [8:0] o;
  logic [7:0] result_next;
  logic       carry_next;
  logic       overflow_next;
  logic       zero_next;
  logic       negative_next;
  logic       extra_next;

  // high part bcd adjust, carry is bit 8 of the adjusted value
  always_comb begin
    if (s2.sub) begin
      dsum = s2.hsum[8] ? s2.hsum : s2.hsum - calu_pkg::HIGH_ADJ;
    end else begin
      dsum = (s2.hsum > calu_pkg::HIGH_LIMIT) ? s2.hsum + calu_pkg::HIGH_ADJ : s2.hsum;
    end
    o = s2.dec ? dsum : s2.bsum;
  end

  // result select and flags
  always_comb begin
    if (s2.arith) begin
      result_next   = o[7:0];
      carry_next    = o[8];
      overflow_next = s2.dec ? s2.v_in : s2.bin_v;
      zero_next     = (o[7:0] == 8'h00);
      negative_next = o[7];
      extra_next    = s2.dec;
    end else begin
      result_next   = s2.r;
      carry_next    = s2.c;
      overflow_next = s2.v;
      zero_next     = s2.z;
      negative_next = s2.n;
      extra_next    = 1'b0;
    end
  end

  // output strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2.valid;
    end
  end

  // output payload, held between items
  always_ff @(posedge clk) begin
    if (s2.valid) begin
      result       <= result_next;
      carry_out    <= carry_next;
      overflow_out <= overflow_next;
      zero_out     <= zero_next;
      negative_out <= negative_next;
      extra_cycle  <= extra_next;
    end
  end

endmodule
